// ===== hdl/tps_pkg.sv =====
// Shared types, constants and the pattern ROM of the tone pattern sequencer.
package tps_pkg;

	localparam int TPS_TIME_BITS         = 32;
	localparam int TPS_MAX_PATTERN_STEPS = 16;
	localparam int NUM_PATTERNS          = 12;
	localparam int HALF_DUTY             = 512;

	localparam int NOW_W  = 32;
	localparam int PREQ_W = 4;
	localparam int FREQ_W = 12;
	localparam int DUTY_W = 10;
	localparam int DUR_W  = 9;
	localparam int VOL_W  = 2;
	localparam int IDX_W  = 6;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_VOLUME = 1'b1;

	localparam logic [VOL_W-1:0] VOL_LOW  = 2'd0;
	localparam logic [VOL_W-1:0] VOL_MED  = 2'd1;
	localparam logic [VOL_W-1:0] VOL_HIGH = 2'd2;

	localparam logic [PREQ_W-1:0] PAT_NONE      = 4'd0;
	localparam logic [PREQ_W-1:0] TICK_PATTERN  = 4'd1;
	localparam logic [PREQ_W-1:0] CLICK_PATTERN = 4'd2;

	localparam logic [DUTY_W-1:0] DUTY_LOW  = DUTY_W'(HALF_DUTY * 20 / 100);
	localparam logic [DUTY_W-1:0] DUTY_MED  = DUTY_W'(HALF_DUTY * 50 / 100);
	localparam logic [DUTY_W-1:0] DUTY_HIGH = DUTY_W'(HALF_DUTY * 100 / 100);

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [DUR_W-1:0]  dur;
	} tps_step_t;

	typedef struct packed {
		logic             enable;
		logic [VOL_W-1:0] volume;
	} tps_cfg_t;

	function automatic logic [DUTY_W-1:0] tps_duty(input logic [VOL_W-1:0] vol);
		logic [DUTY_W-1:0] d;
		case (vol)
			VOL_LOW: d = DUTY_LOW;
			VOL_MED: d = DUTY_MED;
			default: d = DUTY_HIGH;
		endcase
		return d;
	endfunction

	// A zero duration marks the end of a pattern; unlisted entries read as that.
	function automatic tps_step_t tps_rom(input logic [PREQ_W-1:0] sel,
			input logic [IDX_W-1:0] idx);
		tps_step_t s;
		s = '0;
		case (sel)
			4'd1: begin
				case (idx)
					6'd0: s = '{12'd1500, 9'd8};
					default: s = '0;
				endcase
			end
			4'd2: begin
				case (idx)
					6'd0: s = '{12'd2000, 9'd30};
					default: s = '0;
				endcase
			end
			4'd3: begin
				case (idx)
					6'd0: s = '{12'd2000, 9'd60};
					6'd1: s = '{12'd3000, 9'd80};
					default: s = '0;
				endcase
			end
			4'd4: begin
				case (idx)
					6'd0: s = '{12'd1500, 9'd100};
					default: s = '0;
				endcase
			end
			4'd5: begin
				case (idx)
					6'd0: s = '{12'd2000, 9'd100};
					6'd1: s = '{12'd1500, 9'd100};
					6'd2: s = '{12'd1000, 9'd100};
					default: s = '0;
				endcase
			end
			4'd6: begin
				case (idx)
					6'd0, 6'd2, 6'd4: s = '{12'd1000, 9'd100};
					6'd1, 6'd3, 6'd5: s = '{12'd2000, 9'd100};
					default: s = '0;
				endcase
			end
			4'd7: begin
				case (idx)
					6'd0, 6'd2: s = '{12'd2000, 9'd40};
					6'd1: s = '{12'd0, 9'd60};
					default: s = '0;
				endcase
			end
			4'd8: begin
				case (idx)
					6'd0, 6'd2, 6'd4: s = '{12'd2000, 9'd40};
					6'd1, 6'd3: s = '{12'd0, 9'd50};
					default: s = '0;
				endcase
			end
			4'd9: begin
				case (idx)
					6'd0: s = '{12'd3000, 9'd10};
					default: s = '0;
				endcase
			end
			4'd10: begin
				case (idx)
					6'd0: s = '{12'd523, 9'd120};
					6'd1, 6'd3, 6'd5: s = '{12'd0, 9'd40};
					6'd2: s = '{12'd659, 9'd120};
					6'd4: s = '{12'd784, 9'd120};
					6'd6: s = '{12'd1047, 9'd150};
					6'd7: s = '{12'd0, 9'd50};
					6'd8: s = '{12'd1319, 9'd300};
					default: s = '0;
				endcase
			end
			4'd11: begin
				case (idx)
					6'd0: s = '{12'd1175, 9'd100};
					6'd1, 6'd3, 6'd7: s = '{12'd0, 9'd30};
					6'd2: s = '{12'd880, 9'd100};
					6'd4: s = '{12'd698, 9'd120};
					6'd5: s = '{12'd0, 9'd80};
					6'd6: s = '{12'd587, 9'd100};
					6'd8: s = '{12'd880, 9'd200};
					default: s = '0;
				endcase
			end
			4'd12: begin
				case (idx)
					6'd0: s = '{12'd1319, 9'd120};
					6'd1, 6'd3, 6'd5, 6'd7: s = '{12'd0, 9'd40};
					6'd2: s = '{12'd1047, 9'd120};
					6'd4: s = '{12'd784, 9'd120};
					6'd6: s = '{12'd659, 9'd120};
					6'd8: s = '{12'd523, 9'd300};
					default: s = '0;
				endcase
			end
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

// ===== hdl/tps_if.sv =====
// Valid/ready channel interfaces for the update and result streams.
interface tps_in_if;
	logic                        valid;
	logic                        ready;
	logic [tps_pkg::NOW_W-1:0]   now_ms;
	logic                        tick_request;
	logic                        click_request;
	logic [tps_pkg::PREQ_W-1:0]  pattern_request;

	modport source (output valid, now_ms, tick_request, click_request, pattern_request,
		input ready);
	modport sink (input valid, now_ms, tick_request, click_request, pattern_request,
		output ready);
endinterface

interface tps_out_if;
	logic                        valid;
	logic                        ready;
	logic [tps_pkg::FREQ_W-1:0]  tone_freq;
	logic [tps_pkg::DUTY_W-1:0]  tone_duty;
	logic                        busy_res;

	modport source (output valid, tone_freq, tone_duty, busy_res, input ready);
	modport sink (input valid, tone_freq, tone_duty, busy_res, output ready);
endinterface

// ===== hdl/tps_cfg.sv =====
// APB register file holding the enable and volume settings.
module tps_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tps_pkg::PADDR_W-1:0]  paddr,
	input  logic [tps_pkg::PDATA_W-1:0]  pwdata,
	output logic [tps_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output tps_pkg::tps_cfg_t            cfg
);
	import tps_pkg::*;

	logic             enable_q;
	logic [VOL_W-1:0] volume_q;
	logic             reg_sel;
	logic             wr_en;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			volume_q <= VOL_HIGH;
		end else if (wr_en) begin
			case (reg_sel)
				REG_ENABLE: enable_q <= pwdata[0];
				REG_VOLUME: begin
					// Codes above high volume saturate.
					if (pwdata[VOL_W-1:0] > VOL_HIGH) begin
						volume_q <= VOL_HIGH;
					end else begin
						volume_q <= pwdata[VOL_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_ENABLE: prdata = {{(PDATA_W-1){1'b0}}, enable_q};
			REG_VOLUME: prdata = {{(PDATA_W-VOL_W){1'b0}}, volume_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.enable = enable_q;
	assign cfg.volume = volume_q;

endmodule

// ===== hdl/tps_core.sv =====
// Input register, step sequencing logic and result register of the sequencer.
module tps_core #(
	parameter int TIME_BITS         = tps_pkg::TPS_TIME_BITS,
	parameter int MAX_PATTERN_STEPS = tps_pkg::TPS_MAX_PATTERN_STEPS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tps_pkg::tps_cfg_t cfg,
	tps_in_if.sink            cmd,
	tps_out_if.source         tone
);
	import tps_pkg::*;

	localparam int SW = (MAX_PATTERN_STEPS > 1) ? $clog2(MAX_PATTERN_STEPS) : 1;

	// Input stage
	logic              v_s1;
	logic [NOW_W-1:0]  now_s1;
	logic              tick_s1;
	logic              click_s1;
	logic [PREQ_W-1:0] preq_s1;

	// Sequencer state; freq, duty and active also form the result payload.
	logic                 out_valid_q;
	logic                 active_q;
	logic [PREQ_W-1:0]    sel_q;
	logic [SW-1:0]        step_q;
	logic [TIME_BITS-1:0] start_q;
	logic [FREQ_W-1:0]    freq_q;
	logic [DUTY_W-1:0]    duty_q;

	logic                 adv;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] elapsed;
	logic [SW-1:0]        step_inc;
	tps_step_t            cur;
	tps_step_t            nxt;
	tps_step_t            first;
	logic                 req_ok;
	logic                 go;
	logic [PREQ_W-1:0]    begin_sel;

	logic                 active_n;
	logic [PREQ_W-1:0]    sel_n;
	logic [SW-1:0]        step_n;
	logic [TIME_BITS-1:0] start_n;
	logic [FREQ_W-1:0]    freq_n;
	logic [DUTY_W-1:0]    duty_n;

	function automatic tps_step_t rom_at(input logic [PREQ_W-1:0] sel,
			input logic [SW-1:0] idx);
		tps_step_t s;
		s = '0;
		if ({1'b0, idx} < (SW+1)'(MAX_PATTERN_STEPS)) begin
			s = tps_rom(sel, IDX_W'(idx));
		end
		return s;
	endfunction

	assign adv       = v_s1 && (!out_valid_q || tone.ready);
	assign cmd.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd.ready) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			now_s1   <= cmd.now_ms;
			tick_s1  <= cmd.tick_request;
			click_s1 <= cmd.click_request;
			preq_s1  <= cmd.pattern_request;
		end
	end

	always_comb begin
		now_t    = TIME_BITS'(now_s1);
		elapsed  = now_t - start_q;
		step_inc = step_q + 1'b1;
		cur      = rom_at(sel_q, step_q);
		nxt      = rom_at(sel_q, step_inc);

		active_n = active_q;
		sel_n    = sel_q;
		step_n   = step_q;
		start_n  = start_q;
		freq_n   = freq_q;
		duty_n   = duty_q;

		// The running step moves on by at most one step per update.
		if (active_q && (elapsed >= TIME_BITS'(cur.dur))) begin
			step_n = step_inc;
			if (nxt.dur == '0) begin
				active_n = 1'b0;
				sel_n    = PAT_NONE;
				step_n   = '0;
				freq_n   = '0;
				duty_n   = '0;
			end else begin
				start_n = now_t;
				freq_n  = nxt.freq;
				duty_n  = (nxt.freq != '0) ? tps_duty(cfg.volume) : '0;
			end
		end

		// A pattern request overrides a tick or click taken in the same transaction.
		req_ok = cfg.enable && (preq_s1 != PAT_NONE) && (preq_s1 <= PREQ_W'(NUM_PATTERNS));
		go     = 1'b1;
		if (req_ok) begin
			begin_sel = preq_s1;
		end else if (tick_s1 && cfg.enable && !active_n) begin
			begin_sel = TICK_PATTERN;
		end else if (click_s1 && cfg.enable && !active_n) begin
			begin_sel = CLICK_PATTERN;
		end else begin
			begin_sel = PAT_NONE;
			go        = 1'b0;
		end
		first = rom_at(begin_sel, '0);

		if (go) begin
			sel_n    = begin_sel;
			step_n   = '0;
			start_n  = now_t;
			active_n = 1'b1;
			if (first.dur != '0) begin
				freq_n = first.freq;
				duty_n = (first.freq != '0) ? tps_duty(cfg.volume) : '0;
			end else begin
				active_n = 1'b0;
				sel_n    = PAT_NONE;
				freq_n   = '0;
				duty_n   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			active_q    <= 1'b0;
			sel_q       <= PAT_NONE;
			step_q      <= '0;
			start_q     <= '0;
			freq_q      <= '0;
			duty_q      <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				active_q    <= active_n;
				sel_q       <= sel_n;
				step_q      <= step_n;
				start_q     <= start_n;
				freq_q      <= freq_n;
				duty_q      <= duty_n;
			end else if (tone.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign tone.valid     = out_valid_q;
	assign tone.tone_freq = freq_q;
	assign tone.tone_duty = duty_q;
	assign tone.busy_res  = active_q;

	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (sel_q != PAT_NONE) && (sel_q <= PREQ_W'(NUM_PATTERNS)))
		else $error("playing with no valid pattern selected");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (freq_q == '0) && (duty_q == '0) && (sel_q == PAT_NONE))
		else $error("idle sequencer drives a tone");

	a_gap_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(freq_q == '0) |-> (duty_q == '0))
		else $error("nonzero duty during a silent step");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !tone.ready) |=> $stable(step_q) && $stable(start_q)
			&& $stable(active_q))
		else $error("state moved while a result was waiting");

endmodule

// ===== hdl/tone_pattern_sequencer_top.sv =====
// Top level of the tone pattern sequencer: register port and sequencing core.
// Each update transaction carries the millisecond time and the tick, click and
// pattern requests and yields exactly one result: the current frequency, the
// PWM duty and a busy flag. An update passes through one input register and
// one result register and waits in the input register while a result is
// still untaken; a new update is taken in every cycle while results are
// drained; the step ROM lookup, the elapsed-time subtraction and its compare
// all sit between those two registers. Enable and volume are written through
// the APB port at byte addresses 0 and 4; the user must write them only while
// no update is in flight, which the block itself does not enforce; a volume
// change takes effect when the next step begins.
module tone_pattern_sequencer_top #(
	parameter int TIME_BITS         = tps_pkg::TPS_TIME_BITS,
	parameter int MAX_PATTERN_STEPS = tps_pkg::TPS_MAX_PATTERN_STEPS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tps_pkg::PADDR_W-1:0]  paddr,
	input  logic [tps_pkg::PDATA_W-1:0]  pwdata,
	output logic [tps_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	tps_in_if.sink                       cmd,
	tps_out_if.source                    tone
);
	import tps_pkg::*;

	tps_cfg_t cfg;

	tps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tps_core #(
		.TIME_BITS         (TIME_BITS),
		.MAX_PATTERN_STEPS (MAX_PATTERN_STEPS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.tone   (tone)
	);

endmodule
